>>> rtl/brbf_pkg.sv
package brbf_pkg;

    localparam int MODE_W = 3;
    localparam int DATA_W = 8;
    localparam int LEN_W  = 13;
    localparam int CNT_W  = 12;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH = 3'd0,
        MODE_POP  = 3'd1,
        MODE_PEEK = 3'd2,
        MODE_WADV = 3'd3,
        MODE_RADV = 3'd4
    } mode_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_SEND
    } state_e_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
        logic beat_done;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_stat_t;

endpackage

>>> rtl/brbf_ctrl.sv
module brbf_ctrl
    import brbf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_e_t state_reg;
    state_e_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    state_next = stat.last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_FETCH: begin
                cmd.fetch = 1'b1;
            end
            ST_SEND: begin
                m_tvalid      = 1'b1;
                cmd.beat_done = m_tready && !stat.last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/brbf_datapath.sv
module brbf_datapath
    import brbf_pkg::*;
#(
    parameter int DEPTH     = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [MODE_W-1:0] in_mode,
    input  logic [DATA_W-1:0] in_data,
    input  logic [LEN_W-1:0]  in_length,
    output logic [DATA_W-1:0] out_data,
    output logic [CNT_W-1:0]  out_granted,
    output logic [CNT_W-1:0]  out_used,
    output logic [CNT_W-1:0]  out_free,
    output logic [CNT_W-1:0]  out_cfree,
    output logic [CNT_W-1:0]  out_cused
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = (PW > LEN_W) ? PW : LEN_W;
    localparam int BW = $clog2(MAX_BURST + 1);
    localparam logic [PW:0]   DEPTH_X = (PW+1)'(DEPTH);
    localparam logic [PW-1:0] FULL    = PW'(DEPTH - 1);
    localparam logic [CW-1:0] MAXB_X  = CW'(MAX_BURST);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [PW-1:0]     rp_reg;
    logic [PW-1:0]     wp_reg;
    logic [PW-1:0]     used_reg;
    logic [PW-1:0]     cur_reg;
    logic [PW-1:0]     gnt_reg;
    logic [BW-1:0]     rem_reg;
    logic              burst_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [DATA_W-1:0] din_reg;
    logic [LEN_W-1:0]  len_reg;

    logic [PW-1:0]     free_w;
    logic [CW-1:0]     req_x;
    logic [CW-1:0]     avail_x;
    logic [CW-1:0]     n_x;
    logic [PW-1:0]     n;
    logic              grow;
    logic              shrink;
    logic              is_burst;
    logic              push_we;
    logic [PW-1:0]     rp_next;
    logic [PW-1:0]     wp_next;
    logic [PW-1:0]     used_next;
    logic              le;
    logic [PW:0]       cfree_x;
    logic [PW:0]       cused_x;
    logic [PW:0]       diff_x;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                               input logic [PW-1:0] d);
        logic [PW:0] s;
        s = {1'b0, p} + {1'b0, d};
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[PW-1:0];
    endfunction

    assign free_w = FULL - used_reg;

    always_comb begin
        req_x    = CW'(len_reg);
        avail_x  = CW'(used_reg);
        grow     = 1'b0;
        shrink   = 1'b0;
        is_burst = 1'b0;
        unique case (mode_reg)
            MODE_PUSH: begin
                req_x   = CW'(1);
                avail_x = CW'(free_w);
                grow    = 1'b1;
            end
            MODE_WADV: begin
                avail_x = CW'(free_w);
                grow    = 1'b1;
            end
            MODE_POP: begin
                shrink   = 1'b1;
                is_burst = 1'b1;
            end
            MODE_PEEK: begin
                is_burst = 1'b1;
            end
            MODE_RADV: begin
                shrink = 1'b1;
            end
            default: begin
                avail_x = '0;
            end
        endcase
        n_x = (req_x < avail_x) ? req_x : avail_x;
        if (is_burst && (n_x > MAXB_X)) begin
            n_x = MAXB_X;
        end
        n = PW'(n_x);
    end

    assign push_we   = cmd.exec && (mode_reg == MODE_PUSH) && (n != '0);
    assign wp_next   = grow ? wrap_add(wp_reg, n) : wp_reg;
    assign rp_next   = shrink ? wrap_add(rp_reg, n) : rp_reg;
    assign used_next = grow ? (used_reg + n) : (shrink ? (used_reg - n) : used_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg    <= '0;
            wp_reg    <= '0;
            used_reg  <= '0;
            burst_reg <= 1'b0;
            rem_reg   <= '0;
        end else begin
            if (cmd.exec) begin
                rp_reg    <= rp_next;
                wp_reg    <= wp_next;
                used_reg  <= used_next;
                burst_reg <= is_burst && (n != '0);
                rem_reg   <= BW'(n);
            end else if (cmd.beat_done) begin
                rem_reg <= rem_reg - BW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            din_reg  <= in_data;
            len_reg  <= in_length;
        end
        if (cmd.exec) begin
            cur_reg <= rp_reg;
            gnt_reg <= n;
        end else if (cmd.fetch) begin
            cur_reg <= wrap_add(cur_reg, PW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (push_we) begin
            mem[wp_reg] <= din_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            rdata_reg <= mem[cur_reg];
        end
    end

    assign le = rp_reg <= wp_reg;

    always_comb begin
        if (le) begin
            cfree_x = (rp_reg == '0) ? ({1'b0, FULL} - {1'b0, wp_reg})
                                     : (DEPTH_X - {1'b0, wp_reg});
            cused_x = {1'b0, wp_reg} - {1'b0, rp_reg};
        end else begin
            cfree_x = {1'b0, rp_reg} - {1'b0, wp_reg} - (PW+1)'(1);
            cused_x = DEPTH_X - {1'b0, rp_reg};
        end
    end

    assign stat.last   = !burst_reg || (rem_reg == BW'(1));
    assign out_data    = burst_reg ? rdata_reg : '0;
    assign out_granted = CNT_W'(gnt_reg);
    assign out_used    = CNT_W'(used_reg);
    assign out_free    = CNT_W'(free_w);
    assign out_cfree   = CNT_W'(cfree_x);
    assign out_cused   = CNT_W'(cused_x);

    assign diff_x = le ? ({1'b0, wp_reg} - {1'b0, rp_reg})
                       : ({1'b0, wp_reg} + DEPTH_X - {1'b0, rp_reg});

`ifndef SYNTH
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, rp_reg} < DEPTH_X) && ({1'b0, wp_reg} < DEPTH_X))
        else $error("pointer beyond store depth");

    a_used_match: assert property (@(posedge aclk) disable iff (!aresetn)
        diff_x == {1'b0, used_reg})
        else $error("occupancy disagrees with pointers");

    a_beat_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.beat_done |-> (burst_reg && (rem_reg > BW'(1))))
        else $error("burst advanced past its final beat");

    a_exec_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec)
        else $error("loaded item not executed");
`endif

endmodule

>>> rtl/byte_ring_buffer_fifo.sv
// channel  dir  tdata                                          tuser      tlast
// s_       in   data_in[7:0] length[20:8] zero[23:21]          mode[2:0]  -
// m_       out  data_out[7:0] granted[19:8] used_count[31:20]  -          last
//               free_count[43:32] contiguous_free[55:44]
//               contiguous_used[67:56] zero[71:68]
// One item at a time: a push, pointer advance or empty read returns a single
// beat; a pop or peek of n bytes returns n beats, each fetched by a registered
// store read before it is sent.
// Reset (aresetn low, synchronous) empties the FIFO; store contents are kept.
// Output stalls hold the current beat and s_tready stays low until the last
// beat of the item is taken.
module byte_ring_buffer_fifo
    import brbf_pkg::*;
#(
    parameter int DEPTH     = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_in, length, zero pad
    input  logic [2:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // data_out, granted, used_count, free_count,
                                   // contiguous_free, contiguous_used, zero pad
    output logic        m_tlast
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  granted;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  contiguous_free;
    logic [CNT_W-1:0]  contiguous_used;

    brbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brbf_datapath #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_mode     (s_tuser),
        .in_data     (s_tdata[7:0]),
        .in_length   (s_tdata[20:8]),
        .out_data    (data_out),
        .out_granted (granted),
        .out_used    (used_count),
        .out_free    (free_count),
        .out_cfree   (contiguous_free),
        .out_cused   (contiguous_used)
    );

    assign m_tdata = {4'b0000, contiguous_used, contiguous_free, free_count,
                      used_count, granted, data_out};
    assign m_tlast = stat.last;

endmodule
